[rtl/laser_beam_likelihood_accumulator_defines.svh]
// Assertion macros used by the top-level RTL file to check its own logic.
`ifndef LASER_BEAM_LIKELIHOOD_ACCUMULATOR_DEFINES_SVH
`define LASER_BEAM_LIKELIHOOD_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define LBLA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define LBLA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

[rtl/lbla_pkg.sv]
package lbla_pkg;

  localparam int unsigned RANGE_W    = 14;
  localparam int unsigned VAL_W      = 16;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned SUM_W      = 40;
  localparam int unsigned PROD_W     = 2 * VAL_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned DEF_TABLE_DEPTH = 16384;
  localparam int unsigned DEF_FRAC_BITS   = 16;

  localparam logic [VAL_W-1:0]   RST_HIT_WEIGHT   = 16'd62259;
  localparam logic [VAL_W-1:0]   RST_SHORT_WEIGHT = 16'd655;
  localparam logic [VAL_W-1:0]   RST_MAX_WEIGHT   = 16'd3277;
  localparam logic [VAL_W-1:0]   RST_RAND_TERM    = 16'd328;
  localparam logic [RANGE_W-1:0] RST_MAX_RANGE    = 14'd10000;

  typedef enum logic [OP_W-1:0] {
    OP_BEAM       = 2'd0,
    OP_LOAD_HIT   = 2'd1,
    OP_LOAD_SHORT = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIT_WEIGHT   = 3'd0,
    REG_SHORT_WEIGHT = 3'd1,
    REG_MAX_WEIGHT   = 3'd2,
    REG_RAND_TERM    = 3'd3,
    REG_MAX_RANGE    = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PZ,
    ST_SQ,
    ST_CUBE,
    ST_ACC
  } state_t;

  typedef struct packed {
    logic [VAL_W-1:0] hit_weight;
    logic [VAL_W-1:0] short_weight;
    logic [VAL_W-1:0] max_weight;
    logic [VAL_W-1:0] rand_term;
  } lbla_cfg_t;

  typedef struct packed {
    logic mul_en;
    logic pz_en;
    logic sq_en;
    logic cube_en;
  } lbla_ctl_t;

  typedef struct packed {
    logic is_short;
    logic at_max;
    logic last;
  } beam_info_t;

endpackage

[rtl/lbla_tables.sv]
module lbla_tables #(
  parameter int unsigned TABLE_DEPTH = lbla_pkg::DEF_TABLE_DEPTH
) (
  input  logic                             clk,
  input  logic                             wr_hit,
  input  logic                             wr_short,
  input  logic [$clog2(TABLE_DEPTH)-1:0]   wr_addr,
  input  logic [lbla_pkg::VAL_W-1:0]       wr_data,
  input  logic                             rd_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0]   rd_addr_hit,
  input  logic [$clog2(TABLE_DEPTH)-1:0]   rd_addr_short,
  output logic [lbla_pkg::VAL_W-1:0]       rd_hit,
  output logic [lbla_pkg::VAL_W-1:0]       rd_short
);
  import lbla_pkg::*;

  logic [VAL_W-1:0] hit_mem   [TABLE_DEPTH];
  logic [VAL_W-1:0] short_mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      hit_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_hit <= hit_mem[rd_addr_hit];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_short) begin
      short_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_short <= short_mem[rd_addr_short];
    end
  end

endmodule

[rtl/lbla_datapath.sv]
module lbla_datapath #(
  parameter int unsigned FRAC_BITS = lbla_pkg::DEF_FRAC_BITS
) (
  input  logic                         clk,
  input  lbla_pkg::lbla_ctl_t          ctl,
  input  lbla_pkg::lbla_cfg_t          cfg,
  input  lbla_pkg::beam_info_t         info,
  input  logic [lbla_pkg::VAL_W-1:0]   hit_rd,
  input  logic [lbla_pkg::VAL_W-1:0]   short_rd,
  output logic [FRAC_BITS+5:0]         cube
);
  import lbla_pkg::*;

  localparam int unsigned PZ_W   = FRAC_BITS + 2;
  localparam int unsigned SQ_W   = FRAC_BITS + 4;
  localparam int unsigned CUBE_W = FRAC_BITS + 6;
  localparam int unsigned SUMP_W = PROD_W + 2;
  localparam logic [SUMP_W-1:0] PZ_MAX = (SUMP_W'(4) << FRAC_BITS) - SUMP_W'(1);

  logic [PROD_W-1:0]      hit_prod;
  logic [PROD_W-1:0]      short_prod;
  logic [PZ_W-1:0]        pz;
  logic [SQ_W-1:0]        sq;
  logic [SUMP_W-1:0]      pz_sum;
  logic [2*PZ_W-1:0]      sq_full;
  logic [SQ_W+PZ_W-1:0]   cube_full;

  always_comb begin
    pz_sum = SUMP_W'(hit_prod >> FRAC_BITS)
           + (info.is_short ? SUMP_W'(short_prod >> FRAC_BITS) : '0)
           + SUMP_W'(info.at_max ? cfg.max_weight : cfg.rand_term);
    sq_full   = pz * pz;
    cube_full = sq * pz;
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      hit_prod   <= cfg.hit_weight * hit_rd;
      short_prod <= cfg.short_weight * short_rd;
    end
    if (ctl.pz_en) begin
      pz <= (pz_sum > PZ_MAX) ? PZ_W'(PZ_MAX) : PZ_W'(pz_sum);
    end
    if (ctl.sq_en) begin
      sq <= SQ_W'(sq_full >> FRAC_BITS);
    end
    if (ctl.cube_en) begin
      cube <= CUBE_W'(cube_full >> FRAC_BITS);
    end
  end

endmodule

[rtl/laser_beam_likelihood_accumulator.sv]
// Beam sensor-model weight accumulator. Each beam request (operation beam) looks up the hit
// and short exponential tables, forms pz as a fixed-point mixture, cubes it and adds the cube
// to a per-pose sum that starts at 1.0; the request marked last_beam returns the sum on
// weight_update and restarts it at 1.0. Table load requests write one entry and leave the
// block idle and ready. A beam request is taken only while idle, and no next request is taken
// until it is through: the synchronous table read, then the two table multiplies, the mixture
// add, the square, the cube and the accumulate, each registered in turn. A finished weight
// waits in the output register while new requests are taken; only a second last beam waits
// for it to be taken. Configuration is written through cfg_index/cfg_data and is always ready.
module laser_beam_likelihood_accumulator #(
  parameter int unsigned TABLE_DEPTH = lbla_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned FRAC_BITS   = lbla_pkg::DEF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [lbla_pkg::OP_W-1:0]         operation,
  input  logic [lbla_pkg::RANGE_W-1:0]      obs_range_mm,
  input  logic [lbla_pkg::RANGE_W-1:0]      map_range_mm,
  input  logic                              last_beam,
  input  logic [lbla_pkg::RANGE_W-1:0]      table_index,
  input  logic [lbla_pkg::VAL_W-1:0]        table_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lbla_pkg::SUM_W-1:0]        weight_update,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lbla_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lbla_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lbla_pkg::*;
  `include "laser_beam_likelihood_accumulator_defines.svh"

  localparam int unsigned AW     = $clog2(TABLE_DEPTH);
  localparam int unsigned CUBE_W = FRAC_BITS + 6;
  localparam logic [SUM_W-1:0] ONE_FIX = SUM_W'(1) << FRAC_BITS;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  state_t     state, state_next;
  lbla_ctl_t  ctl;
  lbla_cfg_t  cfg;
  beam_info_t info;
  logic [RANGE_W-1:0] max_range;
  logic [SUM_W-1:0]   weight_sum;
  logic [CUBE_W-1:0]  cube;
  logic [VAL_W-1:0]   hit_rd, short_rd;

  logic               in_fire, beam_fire, load_ok, acc_fire;
  logic [RANGE_W-1:0] diff, d_idx, s_idx;
  logic [AW-1:0]      addr_hit, addr_short, addr_wr;
  logic [SUM_W:0]     sum_raw;
  logic [SUM_W-1:0]   sum_sat;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign beam_fire = in_fire && (operation == OP_BEAM);
  assign load_ok   = in_fire && (32'(table_index) < TABLE_DEPTH);

  // Table addresses: capped by the maximum range, then clamped to the table depth.
  always_comb begin
    diff  = (obs_range_mm >= map_range_mm) ? obs_range_mm - map_range_mm
                                           : map_range_mm - obs_range_mm;
    d_idx = (diff < max_range) ? diff : max_range;
    s_idx = (obs_range_mm < max_range) ? obs_range_mm : max_range;
    addr_hit   = (32'(d_idx) >= TABLE_DEPTH) ? AW'(TABLE_DEPTH - 1) : AW'(d_idx);
    addr_short = (32'(s_idx) >= TABLE_DEPTH) ? AW'(TABLE_DEPTH - 1) : AW'(s_idx);
    addr_wr    = AW'(table_index);
  end

  lbla_tables #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_tables (
    .clk           (clk),
    .wr_hit        (load_ok && (operation == OP_LOAD_HIT)),
    .wr_short      (load_ok && (operation == OP_LOAD_SHORT)),
    .wr_addr       (addr_wr),
    .wr_data       (table_value),
    .rd_en         (beam_fire),
    .rd_addr_hit   (addr_hit),
    .rd_addr_short (addr_short),
    .rd_hit        (hit_rd),
    .rd_short      (short_rd)
  );

  lbla_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk      (clk),
    .ctl      (ctl),
    .cfg      (cfg),
    .info     (info),
    .hit_rd   (hit_rd),
    .short_rd (short_rd),
    .cube     (cube)
  );

  always_comb begin
    sum_raw = {1'b0, weight_sum} + (SUM_W + 1)'(cube);
    sum_sat = sum_raw[SUM_W] ? SUM_MAX : sum_raw[SUM_W-1:0];
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    acc_fire   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (beam_fire) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        ctl.mul_en = 1'b1;
        state_next = ST_PZ;
      end
      ST_PZ: begin
        ctl.pz_en  = 1'b1;
        state_next = ST_SQ;
      end
      ST_SQ: begin
        ctl.sq_en  = 1'b1;
        state_next = ST_CUBE;
      end
      ST_CUBE: begin
        ctl.cube_en = 1'b1;
        state_next  = ST_ACC;
      end
      ST_ACC: begin
        // A last beam needs the output register free.
        acc_fire = !info.last || !out_valid || out_ready;
        if (acc_fire) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (beam_fire) begin
      info.is_short <= obs_range_mm < map_range_mm;
      info.at_max   <= obs_range_mm >= max_range;
      info.last     <= last_beam;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hit_weight   <= RST_HIT_WEIGHT;
      cfg.short_weight <= RST_SHORT_WEIGHT;
      cfg.max_weight   <= RST_MAX_WEIGHT;
      cfg.rand_term    <= RST_RAND_TERM;
      max_range        <= RST_MAX_RANGE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HIT_WEIGHT:   cfg.hit_weight   <= cfg_data;
        REG_SHORT_WEIGHT: cfg.short_weight <= cfg_data;
        REG_MAX_WEIGHT:   cfg.max_weight   <= cfg_data;
        REG_RAND_TERM:    cfg.rand_term    <= cfg_data;
        REG_MAX_RANGE:    max_range        <= cfg_data[RANGE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_sum <= ONE_FIX;
      out_valid  <= 1'b0;
    end else begin
      if (acc_fire && info.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (acc_fire) begin
        weight_sum <= info.last ? ONE_FIX : sum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_fire && info.last) begin
      weight_update <= sum_sat;
    end
  end

  `LBLA_ASSERT_NOW(a_sum_floor, clk, rst, 1'b1, weight_sum >= ONE_FIX)
  `LBLA_ASSERT_NEXT(a_beam_starts, clk, rst, beam_fire, state == ST_MUL)
  `LBLA_ASSERT_NOW(a_result_origin, clk, rst, $rose(out_valid), $past(state) == ST_ACC && $past(info.last))

endmodule
